>>> rtl/hla_pkg.sv
`default_nettype none

package hla_pkg;

  // hole list storage
  localparam int HOLE_DEPTH = 1024;
  localparam int HOLE_AW    = $clog2(HOLE_DEPTH);
  localparam int CNT_W      = $clog2(HOLE_DEPTH + 1);

  // field widths
  localparam int SIZE_W  = 16;
  localparam int OFF_W   = 32;
  localparam int HELD_W  = 11;
  localparam int FREE_W  = 26;
  localparam int STAT_W  = 3;
  localparam int POL_W   = 2;

  // counters carry at least the width of their output field
  localparam int TOT_W = (CNT_W > HELD_W) ? CNT_W : HELD_W;
  localparam int SUM_W = (SIZE_W + CNT_W > FREE_W) ? SIZE_W + CNT_W : FREE_W;

  localparam logic [HELD_W-1:0] HELD_MAX = {HELD_W{1'b1}};
  localparam logic [FREE_W-1:0] FREE_MAX = {FREE_W{1'b1}};

  // stream packing
  localparam int IN_DATA_W  = SIZE_W + OFF_W;
  localparam int OUT_BITS   = OFF_W + HELD_W + FREE_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // fit policy codes
  localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POL_W-1:0] POL_WORST = 2'd2;

  // item kinds
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_PLACED    = 3'd0;
  localparam logic [STAT_W-1:0] ST_APPENDED  = 3'd1;
  localparam logic [STAT_W-1:0] ST_FREED     = 3'd2;
  localparam logic [STAT_W-1:0] ST_LIST_FULL = 3'd3;
  localparam logic [STAT_W-1:0] ST_STORE_FULL = 3'd4;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [OFF_W-1:0]  off;
  } hole_t;

  // true if hole a precedes hole b in the list order of the given policy
  function automatic logic goes_before(input logic [POL_W-1:0] pol,
                                       input hole_t a, input hole_t b);
    logic r;
    if (a.size == b.size) r = (a.off < b.off);
    else if (pol == POL_WORST) r = (a.size > b.size);
    else r = (a.size < b.size);
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/hole_list_allocator.sv
`default_nettype none

// Channel   Dir  Handshake            Payload
// cfg       in   cfg_valid/cfg_ready  cfg_data: fit_policy
// s (item)  in   s_tvalid/s_tready    s_tdata: size, offset; s_tuser: mode
// m (res)   out  m_tvalid/m_tready    m_tdata: placed, held, free; m_tuser: status
//
// One item at a time; the memory is walked one entry per cycle over the holes held.
// Allocate: pick scan, removal shift, then an ordered reinsert for best/worst fit
// (position scan + shift up); first fit puts the leftover at the end of the list.
// Free: put at the end under first fit, put in order under best/worst fit.
// s_tready is high only while idle; a result not yet taken holds the sequencer in S_FIN.
// rst (synchronous) empties the list, zeroes the end pointer, sets first fit.

module hole_list_allocator (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [hla_pkg::POL_W-1:0]         cfg_data,     // fit_policy
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [hla_pkg::IN_DATA_W-1:0]     s_tdata,      // region_size, region_offset
  input  wire logic [0:0]                        s_tuser,      // mode
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [hla_pkg::OUT_DATA_W-1:0]         m_tdata,      // placed_offset, holes_held,
                                                               // free_space, zero pad
  output logic [hla_pkg::STAT_W-1:0]             m_tuser       // status
);
  import hla_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PICK = 3'd1;
  localparam logic [2:0] S_RMV  = 3'd2;
  localparam logic [2:0] S_INS  = 3'd3;
  localparam logic [2:0] S_FPOS = 3'd4;
  localparam logic [2:0] S_SHUP = 3'd5;
  localparam logic [2:0] S_PUT  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0]         state;
  logic [POL_W-1:0]   fit_policy;
  logic [TOT_W-1:0]   hole_total;
  logic [SUM_W-1:0]   space_sum;
  logic [OFF_W-1:0]   store_end;

  hole_t              mem [HOLE_DEPTH];
  hole_t              rd_data;
  logic               rd_en, wr_en;
  logic [HOLE_AW-1:0] rd_addr, wr_addr;
  hole_t              wr_data;

  logic [CNT_W-1:0]   idx;
  logic [CNT_W-1:0]   pos;
  logic               rv;
  logic [HOLE_AW-1:0] ri;
  logic               found;
  logic [HOLE_AW-1:0] bi;
  hole_t              best;
  hole_t              new_hole;
  logic [SIZE_W-1:0]  req_size;
  logic [OFF_W-1:0]   placed;
  logic [STAT_W-1:0]  stat;

  logic [CNT_W-1:0]   total_c;
  logic               scan_done;
  logic               pick_hit;
  logic [OFF_W:0]     end_sum;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign total_c   = hole_total[CNT_W-1:0];
  assign scan_done = !rd_en && !rv;
  assign pick_hit  = found && (best.size >= req_size);
  assign end_sum   = {1'b0, store_end} + {{(OFF_W+1-SIZE_W){1'b0}}, req_size};

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx[HOLE_AW-1:0];
    wr_en   = 1'b0;
    wr_addr = ri;
    wr_data = rd_data;
    unique case (state)
      S_PICK, S_FPOS: begin
        rd_en = (idx < total_c);
      end
      S_RMV: begin
        rd_en   = (idx < total_c);
        wr_en   = rv;
        wr_addr = ri - HOLE_AW'(1);
      end
      S_SHUP: begin
        rd_en   = (idx > pos);
        rd_addr = HOLE_AW'(idx - CNT_W'(1));
        wr_en   = rv;
        wr_addr = ri + HOLE_AW'(1);
      end
      S_PUT: begin
        wr_en   = 1'b1;
        wr_addr = pos[HOLE_AW-1:0];
        wr_data = new_hole;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fit_policy <= POL_FIRST;
      hole_total <= '0;
      space_sum  <= '0;
      store_end  <= '0;
      m_tvalid   <= 1'b0;
      rv         <= 1'b0;
      found      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        fit_policy <= cfg_data;
      end
      rv <= rd_en;
      ri <= rd_addr;
      if (rd_en) begin
        if (state == S_SHUP) idx <= idx - CNT_W'(1);
        else idx <= idx + CNT_W'(1);
      end
      // S_FIN handles the output register itself
      if (m_tvalid && m_tready && state != S_FIN) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            req_size     <= s_tdata[SIZE_W-1:0];
            new_hole     <= '{size: s_tdata[SIZE_W-1:0], off: s_tdata[IN_DATA_W-1:SIZE_W]};
            placed       <= '0;
            idx          <= '0;
            found        <= 1'b0;
            if (s_tuser[0] == MODE_FREE) begin
              stat <= ST_FREED;
              if (s_tdata[SIZE_W-1:0] == '0) state <= S_FIN;
              else state <= S_INS;
            end else begin
              state <= S_PICK;
            end
          end
        end
        S_PICK: begin
          if (rv) begin
            if (fit_policy == POL_BEST) begin
              if (rd_data.size >= req_size &&
                  (!found || goes_before(POL_BEST, rd_data, best))) begin
                found <= 1'b1;
                bi    <= ri;
                best  <= rd_data;
              end
            end else if (fit_policy == POL_WORST) begin
              if (!found || goes_before(POL_WORST, rd_data, best)) begin
                found <= 1'b1;
                bi    <= ri;
                best  <= rd_data;
              end
            end else if (!found && rd_data.size >= req_size) begin
              found <= 1'b1;
              bi    <= ri;
              best  <= rd_data;
            end
          end
          if (scan_done) begin
            if (pick_hit) begin
              placed    <= best.off;
              stat      <= ST_PLACED;
              space_sum <= space_sum - {{(SUM_W-SIZE_W){1'b0}}, best.size};
              new_hole  <= '{size: best.size - req_size,
                             off: best.off + {{(OFF_W-SIZE_W){1'b0}}, req_size}};
              idx       <= {{(CNT_W-HOLE_AW){1'b0}}, bi} + CNT_W'(1);
              state     <= S_RMV;
            end else if (end_sum[OFF_W]) begin
              stat  <= ST_STORE_FULL;
              state <= S_FIN;
            end else begin
              placed    <= store_end;
              store_end <= end_sum[OFF_W-1:0];
              stat      <= ST_APPENDED;
              state     <= S_FIN;
            end
          end
        end
        S_RMV: begin
          if (scan_done) begin
            hole_total <= hole_total - TOT_W'(1);
            if (new_hole.size != '0) state <= S_INS;
            else state <= S_FIN;
          end
        end
        S_INS: begin
          if (hole_total >= TOT_W'(HOLE_DEPTH)) begin
            stat  <= ST_LIST_FULL;
            state <= S_FIN;
          end else if (fit_policy == POL_BEST || fit_policy == POL_WORST) begin
            idx   <= '0;
            found <= 1'b0;
            state <= S_FPOS;
          end else begin
            pos   <= total_c;
            state <= S_PUT;
          end
        end
        S_FPOS: begin
          if (rv && !found && goes_before(fit_policy, new_hole, rd_data)) begin
            found <= 1'b1;
            pos   <= {{(CNT_W-HOLE_AW){1'b0}}, ri};
          end
          if (scan_done) begin
            if (!found) pos <= total_c;
            idx   <= total_c;
            state <= S_SHUP;
          end
        end
        S_SHUP: begin
          if (scan_done) state <= S_PUT;
        end
        S_PUT: begin
          hole_total <= hole_total + TOT_W'(1);
          space_sum  <= space_sum + {{(SUM_W-SIZE_W){1'b0}}, new_hole.size};
          state      <= S_FIN;
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= stat;
            m_tdata  <= {{(OUT_DATA_W-OUT_BITS){1'b0}},
                         (space_sum > SUM_W'(FREE_MAX)) ? FREE_MAX : space_sum[FREE_W-1:0],
                         (hole_total > TOT_W'(HELD_MAX)) ? HELD_MAX : hole_total[HELD_W-1:0],
                         placed};
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // the list never holds more entries than its depth HOLE_DEPTH
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    hole_total <= TOT_W'(HOLE_DEPTH))
    else $error("hole count beyond list depth");

  // a free or an error never hands out an offset
  a_no_offset: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == ST_FREED || m_tuser == ST_LIST_FULL ||
                  m_tuser == ST_STORE_FULL)) |-> (m_tdata[OFF_W-1:0] == '0))
    else $error("offset on a non-placing result");

  // end pointer only moves forward
  a_end_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (store_end >= $past(store_end)))
    else $error("store end moved back");

  // an accepted beat starts work
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state != S_IDLE))
    else $error("item accepted but sequencer idle");

endmodule

`default_nettype wire

>>> tb/hole_list_allocator_test.sv
module hole_list_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hla_pkg::*;

  localparam logic [POL_W-1:0]  POL_SPARE   = 2'd3;  // unused code, behaves as first fit
  localparam logic [OFF_W-1:0]  OFF_TOP     = '1;
  localparam logic [SIZE_W-1:0] SIZE_TOP    = '1;
  localparam int                PAD_LO      = OFF_W + HELD_W + FREE_W;
  localparam int                MAX_GAP     = 17;
  localparam int                TAIL_CYCLES = 4 * HOLE_DEPTH + 64;
  localparam int                CYCLE_LIMIT = 30_000_000;

  typedef struct {
    logic [OFF_W-1:0]  placed;
    logic [STAT_W-1:0] status;
    logic [HELD_W-1:0] held;
    logic [FREE_W-1:0] free_sum;
  } outcome_t;

  // Mirror of the hole list, end pointer and policy; holds the outcomes still owed.
  class hole_ledger;
    logic [SIZE_W-1:0] sizes [HOLE_DEPTH];
    logic [OFF_W-1:0]  offs  [HOLE_DEPTH];
    int                count;
    int unsigned       space;
    logic [OFF_W-1:0]  store_top;
    logic [POL_W-1:0]  policy;
    outcome_t          due_results[$];
    int unsigned       bad_results;
    int unsigned       seen_results;
    int unsigned       status_hits [8];

    function new();
      count        = 0;
      space        = 0;
      store_top    = '0;
      policy       = POL_FIRST;
      bad_results  = 0;
      seen_results = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function bit ahead_of(logic [POL_W-1:0] pol, logic [SIZE_W-1:0] sa, logic [OFF_W-1:0] oa,
                          logic [SIZE_W-1:0] sb, logic [OFF_W-1:0] ob);
      if (sa == sb) return oa < ob;
      if (pol == POL_WORST) return sa > sb;
      return sa < sb;
    endfunction

    function bit file_hole(logic [SIZE_W-1:0] sz, logic [OFF_W-1:0] off);
      int pos;
      if (count >= HOLE_DEPTH) return 1'b0;
      pos = count;
      // no resort on a policy change: stop at the first entry the new hole precedes
      if (policy == POL_BEST || policy == POL_WORST) begin
        for (int i = 0; i < count; i++) begin
          if (ahead_of(policy, sz, off, sizes[i], offs[i])) begin
            pos = i;
            break;
          end
        end
      end
      for (int i = count; i > pos; i--) begin
        sizes[i] = sizes[i-1];
        offs[i]  = offs[i-1];
      end
      sizes[pos] = sz;
      offs[pos]  = off;
      count++;
      space += sz;
      return 1'b1;
    endfunction

    function void drop_hole(int at);
      space -= sizes[at];
      for (int i = at + 1; i < count; i++) begin
        sizes[i-1] = sizes[i];
        offs[i-1]  = offs[i];
      end
      count--;
    endfunction

    function int choose_hole(logic [SIZE_W-1:0] req);
      int pick;
      pick = -1;
      for (int i = 0; i < count; i++) begin
        if (policy == POL_BEST) begin
          if (sizes[i] >= req && (pick < 0 ||
              ahead_of(POL_BEST, sizes[i], offs[i], sizes[pick], offs[pick])))
            pick = i;
        end else if (policy == POL_WORST) begin
          if (pick < 0 || ahead_of(POL_WORST, sizes[i], offs[i], sizes[pick], offs[pick]))
            pick = i;
        end else if (sizes[i] >= req) begin
          return i;
        end
      end
      // worst fit only ever looks at the largest hole
      if (policy == POL_WORST && pick >= 0 && sizes[pick] < req) pick = -1;
      return pick;
    endfunction

    function logic [SIZE_W-1:0] largest_hole();
      logic [SIZE_W-1:0] top;
      top = '0;
      for (int i = 0; i < count; i++) if (sizes[i] > top) top = sizes[i];
      return top;
    endfunction

    function void take_request(logic mode, logic [SIZE_W-1:0] sz, logic [OFF_W-1:0] off);
      outcome_t          r;
      int                pick;
      logic [SIZE_W-1:0] hs;
      logic [OFF_W-1:0]  ho;
      logic [OFF_W:0]    reach;
      r.placed = '0;
      if (mode == MODE_FREE) begin
        if (sz == '0) r.status = ST_FREED;
        else if (file_hole(sz, off)) r.status = ST_FREED;
        else r.status = ST_LIST_FULL;
      end else begin
        pick  = choose_hole(sz);
        reach = store_top + sz;
        if (pick >= 0) begin
          hs       = sizes[pick];
          ho       = offs[pick];
          r.placed = ho;
          drop_hole(pick);
          if (hs != sz) void'(file_hole(hs - sz, ho + OFF_W'(sz)));
          r.status = ST_PLACED;
        end else if (reach[OFF_W]) begin
          r.status = ST_STORE_FULL;
        end else begin
          r.placed  = store_top;
          store_top = reach[OFF_W-1:0];
          r.status  = ST_APPENDED;
        end
      end
      r.held     = (count > HELD_MAX) ? HELD_MAX : HELD_W'(count);
      r.free_sum = (space > FREE_MAX) ? FREE_MAX : FREE_W'(space);
      due_results.push_back(r);
    endfunction

    function void match_result(logic [OUT_DATA_W-1:0] data, logic [STAT_W-1:0] st);
      outcome_t          want;
      logic [OFF_W-1:0]  got_placed;
      logic [HELD_W-1:0] got_held;
      logic [FREE_W-1:0] got_free;
      logic [OUT_DATA_W-PAD_LO-1:0] got_pad;
      got_placed = data[OFF_W-1:0];
      got_held   = data[OFF_W +: HELD_W];
      got_free   = data[OFF_W + HELD_W +: FREE_W];
      got_pad    = data[OUT_DATA_W-1:PAD_LO];
      seen_results++;
      if (due_results.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("ERROR: result beat with nothing pending: placed=%h status=%0d held=%0d",
                   got_placed, st, got_held);
        return;
      end
      want = due_results.pop_front();
      status_hits[want.status]++;
      if (got_placed !== want.placed || st !== want.status || got_held !== want.held ||
          got_free !== want.free_sum || got_pad !== '0) begin
        bad_results++;
        if (bad_results <= 10) begin
          $display("ERROR: result %0d expected placed=%h status=%0d held=%0d free=%0d pad=0",
                   seen_results, want.placed, want.status, want.held, want.free_sum);
          $display("       got      placed=%h status=%0d held=%0d free=%0d pad=%0h",
                   got_placed, st, got_held, got_free, got_pad);
        end
      end
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [POL_W-1:0]      cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;   // region_size, region_offset
  logic [0:0]            s_tuser   = '0;   // mode
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;          // placed_offset, holes_held, free_space, pad
  logic [STAT_W-1:0]     m_tuser;          // status

  bit         calm  = 1'b0;   // short sender stretch without gaps
  int         items_sent = 0;
  hole_ledger ledger = new();

  hole_list_allocator u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // tvalid is left high after a beat so back-to-back items never drop it
  task automatic push_item(input logic mode, input logic [SIZE_W-1:0] sz,
                           input logic [OFF_W-1:0] off);
    int gap;
    gap = calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {off, sz};
    s_tuser  <= mode;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    ledger.take_request(mode, sz, off);
    items_sent++;
  endtask

  task automatic set_policy(input logic [POL_W-1:0] pol);
    s_tvalid <= 1'b0;
    while (ledger.due_results.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= pol;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid     <= 1'b0;
    ledger.policy = pol;
  endtask

  task automatic directed_checks();
    set_policy(POL_FIRST);
    push_item(MODE_ALLOC, 16'd0, '0);             // zero-size append keeps the end pointer
    push_item(MODE_ALLOC, 16'd100, OFF_TOP);       // offset ignored on allocate
    push_item(MODE_ALLOC, SIZE_TOP, '0);
    push_item(MODE_FREE, 16'd0, 32'd5);            // zero-size free inserts nothing
    push_item(MODE_FREE, 16'd200, 32'd1000);
    push_item(MODE_FREE, 16'd50, 32'd3000);
    push_item(MODE_FREE, 16'd300, 32'hFFFF_FF00);
    push_item(MODE_FREE, SIZE_TOP, OFF_TOP);
    push_item(MODE_ALLOC, 16'd280, '0);            // leftover offset wraps past zero
    push_item(MODE_ALLOC, 16'd0, '0);              // zero-size take puts the hole back whole
    push_item(MODE_FREE, 16'd200, 32'd1000);       // overlapping, repeated frees
    push_item(MODE_FREE, 16'd200, 32'd1000);
    push_item(MODE_ALLOC, 16'd200, '0);
    push_item(MODE_ALLOC, SIZE_TOP, '0);
    push_item(MODE_ALLOC, 16'd60000, '0);          // taken from what is left of the largest hole
    set_policy(POL_BEST);
    push_item(MODE_FREE, 16'd40, 32'd7);
    push_item(MODE_FREE, 16'd40, 32'd3);
    push_item(MODE_FREE, 16'd40, 32'd3);           // identical hole sorts after its twin
    push_item(MODE_ALLOC, 16'd30, '0);
    set_policy(POL_WORST);
    push_item(MODE_FREE, 16'd500, 32'd9);
    push_item(MODE_FREE, 16'd500, 32'd2);
    push_item(MODE_ALLOC, 16'd600, '0);            // worst fit takes it from the largest hole
    push_item(MODE_ALLOC, 16'd100, '0);
  endtask

  task automatic run_mixed(input logic [POL_W-1:0] pol, input int n);
    int                pick;
    logic              mode;
    logic [SIZE_W-1:0] sz;
    logic [OFF_W-1:0]  off;
    set_policy(pol);
    for (int i = 0; i < n; i++) begin
      calm = (i >= n / 2 && i < n / 2 + 12);
      off  = $urandom();
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        mode = MODE_FREE;
        pick = $urandom_range(0, 19);
        if (pick == 0) sz = '0;
        else if (pick < 3) sz = SIZE_W'($urandom());
        else sz = SIZE_W'($urandom_range(1, 512));
        pick = $urandom_range(0, 9);
        // a few shared offsets make equal-size ties and duplicates likely
        if (pick < 2) off = OFF_W'($urandom_range(0, 7)) << 8;
        else if (pick == 2) off = OFF_TOP - OFF_W'($urandom_range(0, 1023));
      end else begin
        mode = MODE_ALLOC;
        pick = $urandom_range(0, 19);
        if (pick < 6 && ledger.count > 0) sz = ledger.sizes[$urandom_range(0, ledger.count - 1)];
        else if (pick < 8) sz = SIZE_W'($urandom());
        else if (pick == 8) sz = '0;
        else sz = SIZE_W'($urandom_range(1, 600));
      end
      push_item(mode, sz, off);
    end
    calm = 1'b0;
  endtask

  // asking for the largest size is always an exact fit, so each beat removes one hole
  task automatic drain_holes();
    while (ledger.count > 0) push_item(MODE_ALLOC, ledger.largest_hole(), $urandom());
  endtask

  initial begin : result_sink
    int gap;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = (ledger.seen_results % 64 < 10) ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      ledger.match_result(m_tdata, m_tuser);
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles, %0d results still owed",
             CYCLE_LIMIT, ledger.due_results.size());
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    directed_checks();
    run_mixed(POL_BEST, 60);
    run_mixed(POL_WORST, 60);
    run_mixed(POL_SPARE, 40);
    run_mixed(POL_FIRST, 50);
    drain_holes();
    s_tvalid <= 1'b0;
    while (ledger.due_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d items over all policy codes, with ties, wraps and a full drain:",
             items_sent);
    $display("  %0d placed, %0d appended, %0d freed, %0d list full, %0d store full; %0d bad",
             ledger.status_hits[ST_PLACED], ledger.status_hits[ST_APPENDED],
             ledger.status_hits[ST_FREED], ledger.status_hits[ST_LIST_FULL],
             ledger.status_hits[ST_STORE_FULL], ledger.bad_results);
    if (ledger.bad_results == 0 && ledger.due_results.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> files.f
rtl/hla_pkg.sv
rtl/hole_list_allocator.sv
tb/hole_list_allocator_test.sv
